FILE: rtl/wheel_trial_division_factorizer_assert.svh
// Assertion helpers used by the factorizer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef WHEEL_TRIAL_DIVISION_FACTORIZER_ASSERT_SVH
`define WHEEL_TRIAL_DIVISION_FACTORIZER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define WTDF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define WTDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wtdf_pkg.sv
package wtdf_pkg;

  // Default operand width
  localparam int NUMBER_WIDTH_DEF = 32;

  // mod-210 wheel
  localparam int WHEEL_LENGTH = 48;
  localparam int WPOS_W       = $clog2(WHEEL_LENGTH);
  localparam int GAP_W        = 4;

  // Cap on results per number, and the width of the factor count
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Wheel gaps, entry 1 leads from 1 to the first wheel candidate 11
  localparam logic [GAP_W-1:0] WHEEL_GAP [WHEEL_LENGTH] = '{
    4'd2, 4'd10, 4'd2, 4'd4, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6, 4'd4,
    4'd2, 4'd4,  4'd6, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd6, 4'd4,
    4'd6, 4'd8,  4'd4, 4'd2, 4'd4, 4'd2, 4'd4, 4'd8, 4'd6, 4'd4,
    4'd6, 4'd2,  4'd4, 4'd6, 4'd2, 4'd6, 4'd6, 4'd4, 4'd2, 4'd4,
    4'd6, 4'd2,  4'd6, 4'd4, 4'd2, 4'd4, 4'd2, 4'd10
  };

  // Wheel start: first candidate and the gap index that follows it
  localparam int                WHEEL_FIRST_CAND = 11;
  localparam logic [WPOS_W-1:0] WHEEL_FIRST_POS  = WPOS_W'(2);

  // Small primes tried before the wheel
  localparam logic [1:0] SP_LAST = 2'd3;

  function automatic logic [2:0] small_prime(input logic [1:0] idx);
    logic [2:0] p;
    case (idx)
      2'd0:    p = 3'd2;
      2'd1:    p = 3'd3;
      2'd2:    p = 3'd5;
      2'd3:    p = 3'd7;
      default: p = 3'd2;
    endcase
    return p;
  endfunction

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_LOAD,
    S_DIV,
    S_DECIDE,
    S_FOUND,
    S_FIN_PEND,
    S_FIN_REM
  } wtdf_state_t;

endpackage

FILE: rtl/wheel_trial_division_factorizer.sv
// An input of 0 or 1 gives its single result from state S_ONE once the output register is free.
// Each trial divisor runs through load, the serial divider with one quotient bit per cycle
// and the candidate square built alongside, and decide; each factor found adds a found
// step, which may wait on the output; a 32-bit prime takes about 15000 trials.
// Throughput: one number at a time; the next is taken once the last result is queued.
// Reset: rst_n synchronous active low; returns to idle with no result pending.
module wheel_trial_division_factorizer
  import wtdf_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [NUMBER_WIDTH-1:0] out_factor,
  output logic                    out_has_factor,
  output logic                    out_last
);

  localparam int W     = NUMBER_WIDTH;
  localparam int BIT_W = $clog2(W);

  wtdf_state_t state_r, state_nxt;

  // Working registers
  logic [W-1:0]      rem_r, rem_nxt;
  logic [W-1:0]      cand_r, cand_nxt;
  logic [WPOS_W-1:0] wpos_r, wpos_nxt;
  logic              small_r, small_nxt;
  logic [1:0]        sp_idx_r, sp_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [W-1:0]      pend_r, pend_nxt;

  // Serial divider and squarer
  logic [W-1:0]      prem_r, prem_nxt;
  logic [W-1:0]      qd_r, qd_nxt;
  logic [2*W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]      mpl_r, mpl_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [W-1:0]      out_factor_r;
  logic              out_has_r, out_last_r;

  logic              out_free, out_load;
  logic [W-1:0]      out_factor_d;
  logic              out_has_d, out_last_d;
  logic              found_go;

  logic              n_small, rem_gt1, too_big, divisible, at_cap, bit_last;
  logic [W:0]        p_shift, p_sub;
  logic              p_ge;
  logic [W:0]        sq_sum;

  assign out_free  = !out_valid_r || out_ready;
  assign n_small   = (in_number[W-1:1] == '0);
  assign rem_gt1   = (rem_r[W-1:1] != '0);
  assign too_big   = !small_r && (acc_r > {{W{1'b0}}, rem_r});
  assign divisible = (prem_r == '0);
  assign at_cap    = (cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign bit_last  = (bit_r == BIT_W'(W - 1));

  // Restoring division step: one quotient bit per cycle
  assign p_shift = {prem_r, qd_r[W-1]};
  assign p_ge    = (p_shift >= {1'b0, cand_r});
  assign p_sub   = p_shift - {1'b0, cand_r};

  // Shift-add squaring step: one multiplier bit per cycle
  assign sq_sum  = {1'b0, acc_r[2*W-1:W]} + (mpl_r[0] ? {1'b0, cand_r} : '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = n_small ? S_ONE : S_LOAD;
      end
      S_ONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (bit_last) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (too_big || (divisible && at_cap)) begin
          state_nxt = pend_valid_r ? S_FIN_PEND : S_FIN_REM;
        end else if (divisible) begin
          state_nxt = S_FOUND;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_FOUND: begin
        if (!pend_valid_r || out_free) state_nxt = S_LOAD;
      end
      S_FIN_PEND: begin
        if (out_free) state_nxt = rem_gt1 ? S_FIN_REM : S_IDLE;
      end
      S_FIN_REM: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and result load
  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    out_factor_d = pend_r;
    out_has_d    = 1'b1;
    out_last_d   = 1'b0;
    found_go     = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_ONE: begin
        out_load     = out_free;
        out_factor_d = '0;
        out_has_d    = 1'b0;
        out_last_d   = 1'b1;
      end
      S_FOUND: begin
        found_go = !pend_valid_r || out_free;
        out_load = pend_valid_r && out_free;
      end
      S_FIN_PEND: begin
        out_load   = out_free;
        out_last_d = !rem_gt1;
      end
      S_FIN_REM: begin
        out_load     = out_free;
        out_factor_d = rem_r;
        out_last_d   = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    rem_nxt        = rem_r;
    cand_nxt       = cand_r;
    wpos_nxt       = wpos_r;
    small_nxt      = small_r;
    sp_idx_nxt     = sp_idx_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    prem_nxt       = prem_r;
    qd_nxt         = qd_r;
    acc_nxt        = acc_r;
    mpl_nxt        = mpl_r;
    bit_nxt        = bit_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !n_small) begin
          rem_nxt        = in_number;
          small_nxt      = 1'b1;
          sp_idx_nxt     = '0;
          cand_nxt       = W'(small_prime(2'd0));
          cnt_nxt        = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      S_LOAD: begin
        prem_nxt = '0;
        qd_nxt   = rem_r;
        acc_nxt  = '0;
        mpl_nxt  = cand_r;
        bit_nxt  = '0;
      end
      S_DIV: begin
        prem_nxt = p_ge ? p_sub[W-1:0] : p_shift[W-1:0];
        qd_nxt   = {qd_r[W-2:0], p_ge};
        acc_nxt  = {sq_sum, acc_r[W-1:1]};
        mpl_nxt  = {1'b0, mpl_r[W-1:1]};
        bit_nxt  = bit_r + BIT_W'(1);
      end
      S_DECIDE: begin
        // no factor: move to the next trial divisor
        if (!too_big && !divisible) begin
          if (small_r) begin
            if (sp_idx_r == SP_LAST) begin
              small_nxt = 1'b0;
              cand_nxt  = W'(WHEEL_FIRST_CAND);
              wpos_nxt  = WHEEL_FIRST_POS;
            end else begin
              sp_idx_nxt = sp_idx_r + 2'd1;
              cand_nxt   = W'(small_prime(sp_idx_r + 2'd1));
            end
          end else begin
            cand_nxt = cand_r + W'(WHEEL_GAP[wpos_r]);
            wpos_nxt = (wpos_r == WPOS_W'(WHEEL_LENGTH - 1)) ? '0 : wpos_r + WPOS_W'(1);
          end
        end
      end
      S_FOUND: begin
        // hold the new factor back until we know whether it is the last
        if (found_go) begin
          pend_nxt       = cand_r;
          pend_valid_nxt = 1'b1;
          cnt_nxt        = cnt_r + CNT_W'(1);
          rem_nxt        = qd_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      small_r      <= 1'b0;
      sp_idx_r     <= '0;
      cnt_r        <= '0;
      wpos_r       <= '0;
      bit_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      small_r      <= small_nxt;
      sp_idx_r     <= sp_idx_nxt;
      cnt_r        <= cnt_nxt;
      wpos_r       <= wpos_nxt;
      bit_r        <= bit_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    cand_r <= cand_nxt;
    pend_r <= pend_nxt;
    prem_r <= prem_nxt;
    qd_r   <= qd_nxt;
    acc_r  <= acc_nxt;
    mpl_r  <= mpl_nxt;
    if (out_load) begin
      out_factor_r <= out_factor_d;
      out_has_r    <= out_has_d;
      out_last_r   <= out_last_d;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_factor     = out_factor_r;
  assign out_has_factor = out_has_r;
  assign out_last       = out_last_r;

  // Checks
  `include "wheel_trial_division_factorizer_assert.svh"

  `WTDF_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != S_IDLE, "accepted beat did not start work")
  `WTDF_ASSERT_IMPLIES(a_wheel_cand_odd, state_r == S_DECIDE && !small_r, cand_r[0], "even wheel candidate")
  `WTDF_ASSERT_IMPLIES(a_fin_has_pend, state_r == S_FIN_PEND, pend_valid_r, "final flush with no held factor")
  `WTDF_ASSERT_IMPLIES(a_found_below_cap, state_r == S_FOUND, !at_cap, "factor count past result cap")

endmodule
